// File: rtl/label_entropy_plane_select_assert.svh
// assertion macros shared by the plane entropy block
`ifndef LABEL_ENTROPY_PLANE_SELECT_ASSERT_SVH
`define LABEL_ENTROPY_PLANE_SELECT_ASSERT_SVH

// same-cycle implication on clk_i, off during reset
`define LEP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off during reset
`define LEP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/lep_pkg.sv
// package: constants, codes, types and table generators for the plane entropy block
`timescale 1ns / 1ps

package lep_pkg;

  localparam int MAX_DIM        = 256;
  localparam int LANES          = 4;
  localparam int SCORE_BITS     = 16;
  localparam int LOG_TABLE_BITS = 10;

  localparam int ADDR_W  = $clog2(MAX_DIM);
  localparam int DIM_W   = ADDR_W + 1;
  localparam int SUM_W   = 35;
  localparam int H_W     = 16;
  localparam int ACC_W   = 21;
  localparam int S_W     = SCORE_BITS + $clog2(LANES + 1);
  localparam int NUM_W   = SCORE_BITS + LOG_TABLE_BITS + 1;
  localparam int Q_W     = LOG_TABLE_BITS + 1;
  localparam int H_DEPTH = (1 << LOG_TABLE_BITS) + 1;
  localparam int LANE_W  = $clog2(LANES + 1);
  localparam int IDX_W   = (LANES > 1) ? $clog2(LANES) : 1;

  localparam int OP_W     = 2;
  localparam int AXIS_W   = 2;
  localparam int SLICE_W  = 8;
  localparam int BEST_W   = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 9;
  localparam int NL_W     = 3;

  localparam int IN_DATA_W  = ((LANES * SCORE_BITS + AXIS_W + SLICE_W) + 7) / 8 * 8;
  localparam int OUT_DATA_W = ((BEST_W + SUM_W) + 7) / 8 * 8;

  localparam logic [63:0] LN2_Q28 = 64'd186065280;
  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_VOXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_BEST  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ  = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_DONE  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_SLICE = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_BEYOND    = 2'd3;

  // axis codes
  localparam logic [AXIS_W-1:0] AXIS_X   = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y   = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z   = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_BAD = 2'd3;

  // register indexes
  localparam logic [1:0] CFG_SIZE_X     = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y     = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z     = 2'd2;
  localparam logic [1:0] CFG_NUM_LABELS = 2'd3;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [S_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quo;
  } div_rsp_t;

  typedef logic [H_W-1:0]   h_table_t [0:H_DEPTH-1];
  typedef logic [ACC_W-1:0] g_table_t [0:LANES];

  // log2 in Q.30 by repeated squaring
  function automatic logic [63:0] log2_q30(input logic [63:0] v);
    logic [63:0] m;
    logic [63:0] frac;
    int          e;
    e = 0;
    while ((v >> (e + 1)) != 64'd0) e++;
    m = v << (30 - e);
    frac = 64'd0;
    for (int i = 0; i < 30; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(e) << 30) | frac;
  endfunction

  // -q ln q in Q0.16 for share index k
  function automatic logic [63:0] neg_q_ln_q(input logic [63:0] k);
    logic [63:0] d;
    logic [63:0] t;
    if (k == 64'd0) return 64'd0;
    d = (64'(LOG_TABLE_BITS) << 30) - log2_q30(k);
    t = (d * LN2_Q28) >> 28;
    return (k * t + (64'd1 << (LOG_TABLE_BITS + 13))) >> (LOG_TABLE_BITS + 14);
  endfunction

  // n ln n in Q5.16
  function automatic logic [63:0] n_ln_n(input logic [63:0] n);
    logic [63:0] t;
    if (n <= 64'd1) return 64'd0;
    t = (log2_q30(n) * LN2_Q28) >> 28;
    return (n * t + (64'd1 << 13)) >> 14;
  endfunction

  function automatic h_table_t gen_h_table();
    h_table_t tbl;
    for (int k = 0; k < H_DEPTH; k++) tbl[k] = H_W'(neg_q_ln_q(64'(k)));
    return tbl;
  endfunction

  function automatic g_table_t gen_g_table();
    g_table_t tbl;
    for (int n = 0; n <= LANES; n++) tbl[n] = ACC_W'(n_ln_n(64'(n)));
    return tbl;
  endfunction

endpackage

// File: rtl/label_entropy_plane_select.sv
// top level: sequencer, plane sum memories and stream ports of the plane entropy block
`timescale 1ns / 1ps

// Takes one transaction at a time: s_axis_tready_o is high only while the sequencer is idle,
// and a finished result may wait in the output register while the next transaction is
// taken. For a voxel, the shared divider produces one quotient bit a cycle for each lane in
// use with a nonzero score in turn; a lane in use with a zero score is skipped. A zero-sum
// voxel skips the lanes, and a voxel beyond the volume goes straight to the output state. A
// best slice query walks the axis memory one plane a cycle. A clear, and the sweep after
// reset, zero the three plane memories one address a cycle over all 256 addresses, during
// which no transaction is taken. A result that finds the output register still full waits
// in the output state until it drains. Configuration writes are taken at any time and sizes
// take effect at the next clear.

module label_entropy_plane_select import lep_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // tdata: prob_0, prob_1, prob_2, prob_3, axis, slice (lowest bit first), zero padded
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // tuser: op
  input  logic [OP_W-1:0]       s_axis_tuser_i,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // tdata: best_slice, entropy_sum (lowest bit first), zero padded
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // tuser: status
  output logic [STATUS_W-1:0]   m_axis_tuser_o,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  input  logic                  cfg_we_i,
  input  logic [1:0]            cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i
);

  `include "label_entropy_plane_select_assert.svh"

  localparam g_table_t G_TABLE = gen_g_table();

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLR  = 4'd1;
  localparam logic [3:0] ST_SUM  = 4'd2;
  localparam logic [3:0] ST_LANE = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_ACC  = 4'd5;
  localparam logic [3:0] ST_UPD  = 4'd6;
  localparam logic [3:0] ST_QRY  = 4'd7;
  localparam logic [3:0] ST_RD1  = 4'd8;
  localparam logic [3:0] ST_RD2  = 4'd9;
  localparam logic [3:0] ST_SCAN = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (int'(v) > MAX_DIM) return DIM_W'(MAX_DIM);
    return DIM_W'(v);
  endfunction

  logic [3:0]            state_q;
  logic [CFG_W-1:0]      size_x_q, size_y_q, size_z_q;
  logic [NL_W-1:0]       num_labels_q;
  logic [DIM_W-1:0]      dim_x_q, dim_y_q, dim_z_q;
  logic [ADDR_W-1:0]     pos_x_q, pos_y_q;
  logic [DIM_W-1:0]      pos_z_q;
  logic                  vol_done_q;
  logic                  emit_q;
  logic [DIM_W-1:0]      cnt_q;
  logic [ADDR_W-1:0]     cmp_idx_q;
  logic                  cmp_vld_q;
  logic [LANE_W-1:0]     lane_q;
  logic [S_W-1:0]        s_q;
  logic [ACC_W-1:0]      acc_q;
  logic [OP_W-1:0]       op_q;
  logic [SCORE_BITS-1:0] prob_q [LANES];
  logic [AXIS_W-1:0]     axis_q;
  logic [SLICE_W-1:0]    slice_q;
  logic [STATUS_W-1:0]   res_status_q;
  logic [BEST_W-1:0]     res_best_q;
  logic [SUM_W-1:0]      res_sum_q;
  logic                  out_vld_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [BEST_W-1:0]     out_best_q;
  logic [SUM_W-1:0]      out_sum_q;

  logic                  in_acc;
  logic [LANE_W-1:0]     n_use;
  logic [S_W-1:0]        s_calc;
  logic [DIM_W-1:0]      dim_sel;
  logic [SUM_W-1:0]      rd_sel;
  logic [SCORE_BITS-1:0] p_cur;
  logic                  cnt_run;

  logic [SUM_W-1:0]      mem_q [3][MAX_DIM];
  logic [SUM_W-1:0]      rdata_q [3];
  logic [ADDR_W-1:0]     raddr [3];
  logic [ADDR_W-1:0]     waddr [3];
  logic [SUM_W-1:0]      wdata [3];
  logic                  mem_we;
  logic [SUM_W:0]        sum_ext [3];

  div_req_t              div_req;
  div_rsp_t              div_rsp;
  logic [H_W-1:0]        h_val;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == ST_IDLE);

  // lanes in use
  always_comb begin
    if (int'(num_labels_q) > LANES) n_use = LANE_W'(LANES);
    else                            n_use = LANE_W'(num_labels_q);
  end

  // score sum over lanes in use
  always_comb begin
    s_calc = '0;
    for (int i = 0; i < LANES; i++) begin
      if (i < int'(n_use)) s_calc = s_calc + S_W'(prob_q[i]);
    end
  end

  assign p_cur = prob_q[lane_q[IDX_W-1:0]];

  // axis selection for queries
  always_comb begin
    case (axis_q)
      AXIS_X:  begin dim_sel = dim_x_q; rd_sel = rdata_q[0]; end
      AXIS_Y:  begin dim_sel = dim_y_q; rd_sel = rdata_q[1]; end
      default: begin dim_sel = dim_z_q; rd_sel = rdata_q[2]; end
    endcase
  end

  assign cnt_run = cnt_q < dim_sel;

  // memory addressing: voxel positions or the sweep counter
  always_comb begin
    if (op_q == OP_VOXEL && state_q != ST_CLR) begin
      raddr[0] = pos_x_q;
      raddr[1] = pos_y_q;
      raddr[2] = pos_z_q[ADDR_W-1:0];
    end else begin
      for (int m = 0; m < 3; m++) raddr[m] = cnt_q[ADDR_W-1:0];
    end
    for (int m = 0; m < 3; m++) begin
      sum_ext[m] = {1'b0, rdata_q[m]} + (SUM_W + 1)'(acc_q);
      if (state_q == ST_CLR) begin
        waddr[m] = cnt_q[ADDR_W-1:0];
        wdata[m] = '0;
      end else begin
        waddr[m] = raddr[m];
        wdata[m] = sum_ext[m][SUM_W] ? SUM_MAX : sum_ext[m][SUM_W-1:0];
      end
    end
    mem_we = (state_q == ST_CLR) || (state_q == ST_UPD);
  end

  // plane sum memories
  always_ff @(posedge clk_i) begin
    for (int m = 0; m < 3; m++) begin
      if (mem_we) mem_q[m][waddr[m]] <= wdata[m];
      rdata_q[m] <= mem_q[m][raddr[m]];
    end
  end

  // divider request
  assign div_req.start = (state_q == ST_LANE) && (lane_q < n_use) && (p_cur != '0);
  assign div_req.num   = (NUM_W'(p_cur) << LOG_TABLE_BITS) + NUM_W'(s_q >> 1);
  assign div_req.den   = s_q;

  lep_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  lep_hrom u_hrom (
    .clk_i  (clk_i),
    .addr_i (div_rsp.quo),
    .data_o (h_val)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_x_q     <= CFG_W'(256);
      size_y_q     <= CFG_W'(256);
      size_z_q     <= CFG_W'(256);
      num_labels_q <= NL_W'(4);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SIZE_X:     size_x_q     <= cfg_wdata_i;
        CFG_SIZE_Y:     size_y_q     <= cfg_wdata_i;
        CFG_SIZE_Z:     size_z_q     <= cfg_wdata_i;
        CFG_NUM_LABELS: num_labels_q <= cfg_wdata_i[NL_W-1:0];
        default:        ;
      endcase
    end
  end

  // input payload capture
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < LANES; i++) begin
        prob_q[i] <= s_axis_tdata_i[i*SCORE_BITS +: SCORE_BITS];
      end
      axis_q  <= s_axis_tdata_i[LANES*SCORE_BITS +: AXIS_W];
      slice_q <= s_axis_tdata_i[LANES*SCORE_BITS+AXIS_W +: SLICE_W];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      op_q         <= OP_CLEAR;
      dim_x_q      <= DIM_W'(MAX_DIM);
      dim_y_q      <= DIM_W'(MAX_DIM);
      dim_z_q      <= DIM_W'(MAX_DIM);
      pos_x_q      <= '0;
      pos_y_q      <= '0;
      pos_z_q      <= '0;
      vol_done_q   <= 1'b0;
      emit_q       <= 1'b0;
      cnt_q        <= '0;
      cmp_idx_q    <= '0;
      cmp_vld_q    <= 1'b0;
      lane_q       <= '0;
      s_q          <= '0;
      acc_q        <= '0;
      res_status_q <= STAT_OK;
      res_best_q   <= '0;
      res_sum_q    <= '0;
      out_vld_q    <= 1'b0;
      out_status_q <= STAT_OK;
      out_best_q   <= '0;
      out_sum_q    <= '0;
    end else begin
      // output register drains; the output state reloads it itself
      if (out_vld_q && m_axis_tready_i && state_q != ST_OUT) out_vld_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            op_q         <= s_axis_tuser_i;
            res_status_q <= (s_axis_tuser_i == OP_VOXEL && vol_done_q) ? STAT_BEYOND
                                                                       : STAT_OK;
            res_best_q   <= '0;
            res_sum_q    <= '0;
            unique case (s_axis_tuser_i) inside
              OP_CLEAR: begin
                dim_x_q    <= clamp_dim(size_x_q);
                dim_y_q    <= clamp_dim(size_y_q);
                dim_z_q    <= clamp_dim(size_z_q);
                pos_x_q    <= '0;
                pos_y_q    <= '0;
                pos_z_q    <= '0;
                vol_done_q <= 1'b0;
                cnt_q      <= '0;
                emit_q     <= 1'b1;
                state_q    <= ST_CLR;
              end
              OP_VOXEL: begin
                if (vol_done_q) begin
                  state_q <= ST_OUT;
                end else begin
                  state_q <= ST_SUM;
                end
              end
              OP_BEST, OP_READ: state_q <= ST_QRY;
              default: ;
            endcase
          end
        end

        // zero one address of each memory a cycle
        ST_CLR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DIM_W'(MAX_DIM - 1)) begin
            state_q <= emit_q ? ST_OUT : ST_IDLE;
          end
        end

        ST_SUM: begin
          s_q    <= s_calc;
          lane_q <= '0;
          if (s_calc == '0) begin
            acc_q   <= G_TABLE[n_use];
            state_q <= ST_UPD;
          end else begin
            acc_q   <= '0;
            state_q <= ST_LANE;
          end
        end

        // next lane: finish after the lanes in use, skip zero scores, else run the divider
        ST_LANE: begin
          if (lane_q >= n_use) begin
            state_q <= ST_UPD;
          end else if (p_cur == '0) begin
            lane_q <= lane_q + 1'b1;
          end else begin
            state_q <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_rsp.done) state_q <= ST_ACC;
        end

        ST_ACC: begin
          acc_q   <= acc_q + ACC_W'(h_val);
          lane_q  <= lane_q + 1'b1;
          state_q <= ST_LANE;
        end

        // memories written this cycle; advance raster position
        ST_UPD: begin
          res_sum_q <= SUM_W'(acc_q);
          if (DIM_W'(pos_x_q) + 1'b1 >= dim_x_q) begin
            pos_x_q <= '0;
            if (DIM_W'(pos_y_q) + 1'b1 >= dim_y_q) begin
              pos_y_q <= '0;
              pos_z_q <= pos_z_q + 1'b1;
              if (pos_z_q + 1'b1 >= dim_z_q) vol_done_q <= 1'b1;
            end else begin
              pos_y_q <= pos_y_q + 1'b1;
            end
          end else begin
            pos_x_q <= pos_x_q + 1'b1;
          end
          state_q <= ST_OUT;
        end

        ST_QRY: begin
          if (!vol_done_q) begin
            res_status_q <= STAT_NOT_DONE;
            state_q      <= ST_OUT;
          end else if (axis_q == AXIS_BAD) begin
            res_status_q <= STAT_BAD_SLICE;
            state_q      <= ST_OUT;
          end else if (op_q == OP_READ) begin
            if (DIM_W'(slice_q) >= dim_sel) begin
              res_status_q <= STAT_BAD_SLICE;
              state_q      <= ST_OUT;
            end else begin
              cnt_q   <= DIM_W'(slice_q);
              state_q <= ST_RD1;
            end
          end else begin
            cnt_q     <= '0;
            cmp_vld_q <= 1'b0;
            state_q   <= ST_SCAN;
          end
        end

        ST_RD1: state_q <= ST_RD2;

        ST_RD2: begin
          res_sum_q <= rd_sel;
          state_q   <= ST_OUT;
        end

        // one plane a cycle; the compare uses the registered read data and index
        ST_SCAN: begin
          if (cmp_vld_q && (rd_sel > res_sum_q)) begin
            res_sum_q  <= rd_sel;
            res_best_q <= BEST_W'(cmp_idx_q);
          end
          cmp_idx_q <= cnt_q[ADDR_W-1:0];
          cmp_vld_q <= cnt_run;
          if (cnt_run) begin
            cnt_q <= cnt_q + 1'b1;
          end else if (!cmp_vld_q) begin
            state_q <= ST_OUT;
          end
        end

        ST_OUT: begin
          if (!out_vld_q || m_axis_tready_i) begin
            out_vld_q    <= 1'b1;
            out_status_q <= res_status_q;
            out_best_q   <= res_best_q;
            out_sum_q    <= res_sum_q;
            emit_q       <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_sum_q, out_best_q});

  // checks
  `LEP_ASSERT_IMPL(a_div_done_in_div, div_rsp.done, state_q == ST_DIV,
                   "divider finished outside its wait state")
  `LEP_ASSERT_IMPL(a_out_from_out, $rose(m_axis_tvalid_o), $past(state_q) == ST_OUT,
                   "result loaded outside the output state")
  `LEP_ASSERT_IMPL(a_no_write_done, state_q == ST_UPD, !vol_done_q,
                   "plane sums updated after the volume completed")
  `LEP_ASSERT_IMPL(a_lane_range, state_q == ST_ACC, lane_q < n_use,
                   "lane accumulated beyond the lanes in use")
  `LEP_ASSERT_NEXT(a_start_div, div_req.start, state_q == ST_DIV,
                   "divider started without waiting for it")

endmodule

// File: rtl/lep_div.sv
// iterative restoring divider giving the lane share index, one quotient bit a cycle
`timescale 1ns / 1ps

module lep_div import lep_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int DSH_W = S_W + LOG_TABLE_BITS;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [NUM_W-1:0] rem_q;
  logic [DSH_W-1:0] dsh_q;
  logic [Q_W-1:0]   quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;
  logic             fits;

  // trial subtract of the shifted divisor
  assign fits = {{(DSH_W - NUM_W){1'b0}}, rem_q} >= dsh_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(Q_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.num;
      dsh_q <= {req_i.den, {LOG_TABLE_BITS{1'b0}}};
      quo_q <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - dsh_q[NUM_W-1:0];
        quo_q <= {quo_q[Q_W-2:0], 1'b1};
      end else begin
        quo_q <= {quo_q[Q_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

// File: rtl/lep_hrom.sv
// -q ln q lookup rom in Q0.16 with registered read
`timescale 1ns / 1ps

module lep_hrom import lep_pkg::*; (
  input  logic           clk_i,
  input  logic [Q_W-1:0] addr_i,
  output logic [H_W-1:0] data_o
);

  localparam h_table_t H_TABLE = gen_h_table();

  logic [H_W-1:0] data_q;

  // registered table read
  always_ff @(posedge clk_i) begin
    data_q <= H_TABLE[addr_i];
  end

  assign data_o = data_q;

endmodule
